>>> sv/lzce_pkg.sv
// ----------------------------------------------------------------------------
// lzce_pkg: shared definitions for the LoG zero-crossing edge block
// Widths, register indexes and the types passed between the top level and the
// strength datapath.
// ----------------------------------------------------------------------------
package lzce_pkg;

   // value and geometry widths
   localparam int VALUE_BITS    = 24;
   localparam int MAX_WIDTH     = 2048;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int DIM_BITS      = 12;
   localparam int MIN_DIM       = 3;
   localparam int STRENGTH_BITS = 24;
   localparam int STRENGTH_MAX  = (1 << STRENGTH_BITS) - 1;

   // stream and register port widths
   localparam int REQ_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = STRENGTH_BITS + DIM_BITS + COL_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 24;

   // register reset values
   localparam int RESET_IMAGE_WIDTH    = 640;
   localparam int RESET_IMAGE_HEIGHT   = 480;
   localparam int RESET_EDGE_THRESHOLD = 0;

   // register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // 3x3 neighborhood, index row*3+col, top-left first
   typedef logic [8:0][VALUE_BITS-1:0] window_type;

   // stage loads for the strength datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
   } strength_ctl_type;

   // position of the window center that travels with an item
   typedef struct packed {
      logic [DIM_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                last;
   } meta_type;

endpackage

>>> sv/log_zero_crossing_edge.sv
// Path: an accepted item passes the line store read, the window, strength
// stage a and the result register in that order before it is on rsp.
// Throughput: one item per cycle; every stage holds its own item, so the input
// side keeps taking items while a result waits on a stalled output, until the
// stages behind it are full.
// Reset: counters, window, stage valids and registers (640, 480, 0) clear at
// once; the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// log_zero_crossing_edge: LoG zero-crossing edge strength over a pixel stream
// Two line stores and a 3x3 window track the neighborhood; one strength per
// interior pixel with its row, column and an end-of-frame flag.
// ----------------------------------------------------------------------------
module log_zero_crossing_edge (
   input  logic                                 clock,
   input  logic                                 reset,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lzce_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // log_value
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lzce_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // edge_strength, out_row, out_col
   output logic                                 rsp_tlast,  // frame_last
   // register writes
   input  logic                                 csr_wr_en,
   input  logic [lzce_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [lzce_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lzce_pkg::*;

   // registers
   logic [DIM_BITS-1:0]        width_ff, height_ff;
   logic [STRENGTH_BITS-1:0]   thresh_ff;
   logic [DIM_BITS-1:0]        w_cl, h_cl;

   // position counters
   logic [COL_BITS-1:0]        col_ff;
   logic [DIM_BITS-1:0]        row_ff;
   logic [COL_BITS:0]          col_inc;
   logic [DIM_BITS:0]          row_inc;
   logic                       end_row, end_frame;

   // stage control
   logic                       accept;
   logic                       o_go;
   logic                       b_move, b_free;
   logic                       w_move, w_free;
   logic                       s1_move, s1_free;

   // stage 1: accepted item and line store read
   logic                       s1_v_ff;
   logic                       s1_res_ff;
   logic [COL_BITS-1:0]        s1_addr_ff;
   logic [VALUE_BITS-1:0]      s1_value_ff;
   meta_type                   s1_meta_ff, meta_in;
   logic                       res_in;
   logic [2*VALUE_BITS-1:0]    line_mem [MAX_WIDTH];
   logic [2*VALUE_BITS-1:0]    rd_ff;

   // stage 2: window
   window_type                 win_ff, win_in;
   logic                       w_v_ff;
   meta_type                   w_meta_ff;

   // stage 3 and result register
   logic                       b_v_ff;
   meta_type                   b_meta_ff;
   logic                       rsp_v_ff;
   meta_type                   rsp_meta_ff;
   strength_ctl_type           sctl;
   logic [STRENGTH_BITS-1:0]   strength;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(RESET_IMAGE_WIDTH);
         height_ff <= DIM_BITS'(RESET_IMAGE_HEIGHT);
         thresh_ff <= STRENGTH_BITS'(RESET_EDGE_THRESHOLD);
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[DIM_BITS-1:0];
            CSR_EDGE_THRESHOLD: thresh_ff <= csr_wdata[STRENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp frame size
   always_comb begin
      if (width_ff < DIM_BITS'(MIN_DIM)) begin
         w_cl = DIM_BITS'(MIN_DIM);
      end else if (width_ff > DIM_BITS'(MAX_WIDTH)) begin
         w_cl = DIM_BITS'(MAX_WIDTH);
      end else begin
         w_cl = width_ff;
      end
      h_cl = (height_ff < DIM_BITS'(MIN_DIM)) ? DIM_BITS'(MIN_DIM) : height_ff;
   end

   // stage handshake, each stage moves when the one after it has room
   always_comb begin
      o_go       = !rsp_v_ff || rsp_tready;
      b_move     = b_v_ff && o_go;
      b_free     = !b_v_ff || o_go;
      w_move     = w_v_ff && b_free;
      w_free     = !w_v_ff || b_free;
      s1_move    = s1_v_ff && w_free;
      s1_free    = !s1_v_ff || w_free;
      req_tready = s1_free;
      accept     = req_tvalid && s1_free;
   end

   // row and column bookkeeping for the arriving item
   always_comb begin
      col_inc   = {1'b0, col_ff} + 1'b1;
      row_inc   = {1'b0, row_ff} + 1'b1;
      end_row   = ((DIM_BITS+1)'(col_inc) >= {1'b0, w_cl});
      end_frame = (row_inc >= {1'b0, h_cl});
      res_in    = (row_ff >= DIM_BITS'(2)) && (col_ff >= COL_BITS'(2))
                  && (row_ff < h_cl) && ({1'b0, col_ff} < (COL_BITS+1)'(w_cl));
      meta_in.row  = row_ff - 1'b1;
      meta_in.col  = col_ff - 1'b1;
      meta_in.last = (row_ff == h_cl - 1'b1)
                     && ({1'b0, col_ff} == (COL_BITS+1)'(w_cl - 1'b1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (end_row) begin
            col_ff <= '0;
            row_ff <= end_frame ? '0 : row_inc[DIM_BITS-1:0];
         end else begin
            col_ff <= col_inc[COL_BITS-1:0];
         end
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff <= 1'b1;
      end else if (s1_move) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff   <= res_in;
         s1_addr_ff  <= col_ff;
         s1_value_ff <= req_tdata[VALUE_BITS-1:0];
         s1_meta_ff  <= meta_in;
      end
   end

   // line stores as one memory: upper in the high half, middle in the low
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (s1_move) begin
         line_mem[s1_addr_ff] <= {rd_ff[VALUE_BITS-1:0], s1_value_ff};
      end
   end

   // window shifts left, new column from the line stores and the item
   always_comb begin
      win_in    = win_ff;
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[2] = rd_ff[2*VALUE_BITS-1:VALUE_BITS];
      win_in[5] = rd_ff[VALUE_BITS-1:0];
      win_in[8] = s1_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         w_v_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            win_ff <= win_in;
            w_v_ff <= s1_res_ff;
         end else if (w_move) begin
            w_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         w_meta_ff <= s1_meta_ff;
      end
   end

   // strength stage a and result register valids
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (w_move) begin
            b_v_ff <= 1'b1;
         end else if (b_move) begin
            b_v_ff <= 1'b0;
         end
         if (o_go) begin
            rsp_v_ff <= b_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (w_move) begin
         b_meta_ff <= w_meta_ff;
      end
      if (b_move) begin
         rsp_meta_ff <= b_meta_ff;
      end
   end

   assign sctl.load_a = w_move;
   assign sctl.load_b = b_move;

   lzce_strength u_strength (
      .clock     (clock),
      .ctl       (sctl),
      .window    (win_ff),
      .threshold (thresh_ff),
      .strength  (strength)
   );

   // result stream
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = rsp_meta_ff.last;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_meta_ff.col, rsp_meta_ff.row, strength});

`ifndef SYNTHESIS
   // an accepted item always lands in stage 1
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_v_ff)
      else $error("accepted item missing from stage 1");

   // a nonzero strength is never below the threshold
   a_threshold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && (strength != '0) |-> (strength >= thresh_ff))
      else $error("strength below threshold delivered");

   // the end-of-frame item sits at the last interior row and column
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_meta_ff.last |->
         (rsp_meta_ff.row == h_cl - DIM_BITS'(2))
         && (rsp_meta_ff.col == COL_BITS'(w_cl - DIM_BITS'(2))))
      else $error("frame end flagged away from last interior pixel");

   // border pixels never produce a result
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_meta_ff.row != '0) && (rsp_meta_ff.col != '0))
      else $error("result for a border pixel");
`endif

endmodule

>>> sv/lzce_strength.sv
// ----------------------------------------------------------------------------
// lzce_strength: zero-crossing strength of a 3x3 window
// Two register stages: pair gradients and neighbor extremes, then the
// selection by center sign, saturation and threshold.
// ----------------------------------------------------------------------------
module lzce_strength (
   input  logic                                 clock,
   input  lzce_pkg::strength_ctl_type           ctl,
   input  lzce_pkg::window_type                 window,
   input  logic [lzce_pkg::STRENGTH_BITS-1:0]   threshold,
   output logic [lzce_pkg::STRENGTH_BITS-1:0]   strength
);
   import lzce_pkg::*;

   localparam int EXT_BITS = VALUE_BITS + STRENGTH_BITS;

   value_type                        w [9];
   logic [3:0][VALUE_BITS-1:0]       grad_in;
   logic [3:0][VALUE_BITS-1:0]       grad_ff;
   value_type                        lo_in, hi_in;
   value_type                        lo_ff, hi_ff, ctr_ff;
   logic [VALUE_BITS-1:0]            gmax01, gmax23, gmax;
   logic signed [VALUE_BITS:0]       pos_diff, neg_diff;
   logic [VALUE_BITS-1:0]            raw;
   logic [EXT_BITS-1:0]              raw_ext;
   logic [STRENGTH_BITS-1:0]         sat;
   logic [STRENGTH_BITS-1:0]         strength_in;
   logic [STRENGTH_BITS-1:0]         strength_ff;

   // absolute difference of a pair with strictly opposite signs
   function automatic logic [VALUE_BITS-1:0] pair_grad(input value_type a, input value_type b);
      logic signed [VALUE_BITS:0] d;
      logic                       opp;
      opp = ((a > 0) && (b < 0)) || ((a < 0) && (b > 0));
      d = (a > b) ? ((VALUE_BITS+1)'(a) - (VALUE_BITS+1)'(b))
                  : ((VALUE_BITS+1)'(b) - (VALUE_BITS+1)'(a));
      return opp ? d[VALUE_BITS-1:0] : '0;
   endfunction

   function automatic value_type min2(input value_type a, input value_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic value_type max2(input value_type a, input value_type b);
      return (a > b) ? a : b;
   endfunction

   // signed view of the window
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         w[i] = value_type'(window[i]);
      end
   end

   // stage a: opposite pair gradients and neighbor min/max trees
   always_comb begin
      grad_in[0] = pair_grad(w[8], w[0]);
      grad_in[1] = pair_grad(w[7], w[1]);
      grad_in[2] = pair_grad(w[6], w[2]);
      grad_in[3] = pair_grad(w[5], w[3]);
      lo_in = min2(min2(min2(w[0], w[1]), min2(w[2], w[3])),
                   min2(min2(w[5], w[6]), min2(w[7], w[8])));
      hi_in = max2(max2(max2(w[0], w[1]), max2(w[2], w[3])),
                   max2(max2(w[5], w[6]), max2(w[7], w[8])));
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         grad_ff <= grad_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         ctr_ff  <= w[4];
      end
   end

   // stage b: pick by center sign, saturate, apply threshold
   always_comb begin
      gmax01   = (grad_ff[0] > grad_ff[1]) ? grad_ff[0] : grad_ff[1];
      gmax23   = (grad_ff[2] > grad_ff[3]) ? grad_ff[2] : grad_ff[3];
      gmax     = (gmax01 > gmax23) ? gmax01 : gmax23;
      pos_diff = (VALUE_BITS+1)'(ctr_ff) - (VALUE_BITS+1)'(lo_ff);
      neg_diff = (VALUE_BITS+1)'(hi_ff) - (VALUE_BITS+1)'(ctr_ff);
      if (ctr_ff == '0) begin
         raw = gmax;
      end else if (ctr_ff > 0) begin
         raw = (lo_ff < 0) ? pos_diff[VALUE_BITS-1:0] : '0;
      end else begin
         raw = (hi_ff > 0) ? neg_diff[VALUE_BITS-1:0] : '0;
      end
      raw_ext = EXT_BITS'(raw);
      sat = (raw_ext > EXT_BITS'(STRENGTH_MAX)) ? STRENGTH_BITS'(STRENGTH_MAX)
                                                : raw_ext[STRENGTH_BITS-1:0];
      strength_in = (sat < threshold) ? '0 : sat;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_b) begin
         strength_ff <= strength_in;
      end
   end

   assign strength = strength_ff;

endmodule
